// ===== design/sbrs_pkg.sv =====
// ----------------------------------------------------------------------------
// sbrs_pkg: shared types and constants for the sparse binary row store
// Sizes, status codes, controller states and control structs.
// ----------------------------------------------------------------------------
package sbrs_pkg;

    localparam int MAX_ROWS    = 256;
    localparam int MAX_ENTRIES = 1024;
    localparam int COL_BITS    = 16;

    localparam int ROW_W = $clog2(MAX_ROWS);           // row index
    localparam int PTR_W = $clog2(MAX_ROWS + 1);       // pointer index 0..MAX_ROWS
    localparam int ADR_W = $clog2(MAX_ENTRIES);        // store address
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);    // counts 0..MAX_ENTRIES

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_ROW_OOR = 3'd2,
        ST_FULL    = 3'd3,
        ST_POS_OOR = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,      // zero row pointers after reset
        S_IDLE,
        S_PTR0,       // read row_start[row]
        S_PTR1,       // read row_start[row+1]
        S_DECIDE,
        S_RD_WAIT,    // read data of store pending
        S_SCAN,       // compare store word
        S_SHIFT,      // move store words up
        S_PUT,        // write new column
        S_INC,        // bump later pointers
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_step;     // write zero at pointer counter, advance
        logic load_req;     // capture request
        logic rd_ptr_lo;    // issue read of row_start[row]
        logic rd_ptr_hi;    // issue read of row_start[row+1]
        logic cap_lo;       // capture pointer read data as base
        logic cap_hi;       // capture pointer read data as end
        logic scan_start;   // read store[base+position] for a read request
        logic scan_next;    // k++, read store[base+k]
        logic shift_start;  // i = total, read store[total-1]
        logic shift_step;   // write store[i], i--, read store[i-1]
        logic put;          // write store[at] = col
        logic inc_start;    // pointer index = row+1
        logic inc_step;     // read-modify-write pointer
        logic commit;       // total++, span update
        logic set_status;
        status_t status;
        logic set_value;    // never driven; the read value is captured after scan_start
        logic out_load;     // result to output register
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic row_oor;
        logic pos_ok;       // position < count
        logic scan_end;     // k reached n or address limit
        logic hit_eq;
        logic hit_gt;
        logic full;
        logic shift_done;   // i == at
        logic inc_last;
        logic inc_pend;     // pointer read outstanding
        logic is_read;
    } sts_t;

endpackage

// ===== design/sbrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbrs_ctrl: request sequencer
// Steps through pointer reads, row scan, shift, pointer update and result.
// ----------------------------------------------------------------------------
module sbrs_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            out_busy,
    input  sbrs_pkg::sts_t  sts,
    output sbrs_pkg::ctl_t  ctl
);

    sbrs_pkg::state_t state_reg, state_next;
    logic inc_ph_reg, inc_ph_next;   // 0 issue read, 1 write back

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= sbrs_pkg::S_CLEAR;
            inc_ph_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            inc_ph_reg <= inc_ph_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        inc_ph_next = inc_ph_reg;
        ctl         = '0;
        ctl.status  = sbrs_pkg::ST_OK;
        s_ready     = 1'b0;
        case (state_reg)
            sbrs_pkg::S_CLEAR: begin
                ctl.clr_step = 1'b1;
                if (sts.clr_last) state_next = sbrs_pkg::S_IDLE;
            end
            sbrs_pkg::S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctl.load_req = 1'b1;
                    state_next   = sbrs_pkg::S_PTR0;
                end
            end
            sbrs_pkg::S_PTR0: begin
                ctl.rd_ptr_lo = 1'b1;
                state_next    = sbrs_pkg::S_PTR1;
            end
            sbrs_pkg::S_PTR1: begin
                ctl.cap_lo    = 1'b1;
                ctl.rd_ptr_hi = 1'b1;
                state_next    = sbrs_pkg::S_DECIDE;
            end
            sbrs_pkg::S_DECIDE: begin
                ctl.cap_hi = 1'b1;
                if (sts.row_oor) begin
                    ctl.set_status = 1'b1;
                    ctl.status     = sbrs_pkg::ST_ROW_OOR;
                    state_next     = sbrs_pkg::S_DONE;
                end else if (sts.is_read) begin
                    state_next = sbrs_pkg::S_RD_WAIT;
                end else begin
                    state_next = sbrs_pkg::S_SCAN;
                end
            end
            sbrs_pkg::S_RD_WAIT: begin
                // end pointer valid now; pos check and store read
                if (!sts.pos_ok) begin
                    ctl.set_status = 1'b1;
                    ctl.status     = sbrs_pkg::ST_POS_OOR;
                    state_next     = sbrs_pkg::S_DONE;
                end else begin
                    ctl.scan_start = 1'b1;
                    ctl.set_status = 1'b1;
                    ctl.status     = sbrs_pkg::ST_OK;
                    state_next     = sbrs_pkg::S_DONE;
                end
            end
            sbrs_pkg::S_SCAN: begin
                // first entry: issue read; later: compare data of previous read
                if (sts.scan_end) begin
                    if (sts.full) begin
                        ctl.set_status = 1'b1;
                        ctl.status     = sbrs_pkg::ST_FULL;
                        state_next     = sbrs_pkg::S_DONE;
                    end else begin
                        ctl.shift_start = 1'b1;
                        state_next      = sbrs_pkg::S_SHIFT;
                    end
                end else begin
                    ctl.scan_next = 1'b1;
                    state_next    = sbrs_pkg::S_SCAN;
                    if (sts.hit_eq) begin
                        ctl.scan_next  = 1'b0;
                        ctl.set_status = 1'b1;
                        ctl.status     = sbrs_pkg::ST_DUP;
                        state_next     = sbrs_pkg::S_DONE;
                    end else if (sts.hit_gt) begin
                        ctl.scan_next = 1'b0;
                        if (sts.full) begin
                            ctl.set_status = 1'b1;
                            ctl.status     = sbrs_pkg::ST_FULL;
                            state_next     = sbrs_pkg::S_DONE;
                        end else begin
                            ctl.shift_start = 1'b1;
                            state_next      = sbrs_pkg::S_SHIFT;
                        end
                    end
                end
            end
            sbrs_pkg::S_SHIFT: begin
                if (sts.shift_done) begin
                    ctl.put    = 1'b1;
                    state_next = sbrs_pkg::S_PUT;
                end else begin
                    ctl.shift_step = 1'b1;
                end
            end
            sbrs_pkg::S_PUT: begin
                ctl.inc_start  = 1'b1;
                ctl.commit     = 1'b1;
                ctl.set_status = 1'b1;
                ctl.status     = sbrs_pkg::ST_OK;
                inc_ph_next    = 1'b0;
                state_next     = sbrs_pkg::S_INC;
            end
            sbrs_pkg::S_INC: begin
                ctl.inc_step = 1'b1;
                inc_ph_next  = ~inc_ph_reg;
                if (inc_ph_reg && sts.inc_last) state_next = sbrs_pkg::S_DONE;
            end
            sbrs_pkg::S_DONE: begin
                if (!out_busy) begin
                    ctl.out_load = 1'b1;
                    state_next   = sbrs_pkg::S_IDLE;
                end
            end
            default: state_next = sbrs_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== design/sbrs_dpath.sv =====
// ----------------------------------------------------------------------------
// sbrs_dpath: pointer memory, column store, counters and result register
// Registered read data in both; the column store has a separate read address.
// ----------------------------------------------------------------------------
module sbrs_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [8:0]                    num_rows,
    input  logic                          s_req_type,
    input  logic [7:0]                    s_row,
    input  logic [15:0]                   s_col,
    input  logic [9:0]                    s_position,
    input  sbrs_pkg::ctl_t                ctl,
    output sbrs_pkg::sts_t                sts,
    output logic                          out_busy,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [15:0]                   m_col_value,
    output logic [10:0]                   m_row_count,
    output logic [10:0]                   m_total_count,
    output logic [16:0]                   m_col_span
);

    localparam int P_W = sbrs_pkg::PTR_W;
    localparam int A_W = sbrs_pkg::ADR_W;
    localparam int C_W = sbrs_pkg::CNT_W;
    localparam int K_W = sbrs_pkg::COL_BITS;

    logic [C_W-1:0] ptr_mem [sbrs_pkg::MAX_ROWS+1];
    logic [K_W-1:0] col_mem [sbrs_pkg::MAX_ENTRIES];

    logic           req_reg;
    logic [sbrs_pkg::ROW_W-1:0] row_reg;
    logic [K_W-1:0] col_reg;
    logic [9:0]     pos_reg;
    logic [C_W-1:0] base_reg, end_reg, total_reg;
    logic [C_W-1:0] k_reg, i_reg;
    logic [K_W:0]   span_reg;
    logic [P_W-1:0] pidx_reg;
    logic [C_W-1:0] ptr_q_reg;
    logic [K_W-1:0] col_q_reg;
    logic           scan_vld_reg;
    logic           inc_ph_reg;
    sbrs_pkg::status_t stat_reg;
    logic [K_W-1:0] val_reg;
    logic           val_cap_reg;
    logic           mv_reg;
    logic [2:0]     o_stat_reg;
    logic [15:0]    o_val_reg;
    logic [10:0]    o_rc_reg, o_tc_reg;
    logic [16:0]    o_span_reg;

    logic [8:0]     rows_lim;
    logic [C_W-1:0] cnt, at_addr, ins_at;
    logic [C_W:0]   scan_addr, rd_addr;

    assign rows_lim  = (num_rows > 9'(sbrs_pkg::MAX_ROWS)) ? 9'(sbrs_pkg::MAX_ROWS) : num_rows;
    assign cnt       = end_reg - base_reg;
    assign scan_addr = {1'b0, base_reg} + {1'b0, k_reg};
    assign rd_addr   = {1'b0, base_reg} + (C_W+1)'(pos_reg);
    assign at_addr   = scan_addr[C_W-1:0];
    assign ins_at    = (at_addr > total_reg) ? total_reg : at_addr;

    // pointer memory port
    logic           p_we;
    logic [P_W-1:0] p_addr;
    logic [C_W-1:0] p_wd;
    always_comb begin
        p_we   = 1'b0;
        p_addr = pidx_reg;
        p_wd   = '0;
        if (ctl.clr_step) begin
            p_we = 1'b1;
        end else if (ctl.rd_ptr_lo) begin
            p_addr = P_W'(row_reg);
        end else if (ctl.rd_ptr_hi) begin
            p_addr = P_W'(row_reg) + P_W'(1);
        end else if (ctl.inc_step && inc_ph_reg) begin
            p_we = 1'b1;
            p_wd = ptr_q_reg + C_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (p_we) ptr_mem[p_addr] <= p_wd;
        ptr_q_reg <= ptr_mem[p_addr];
    end

    // column store port
    logic           c_we;
    logic [A_W-1:0] c_addr;
    logic [K_W-1:0] c_wd;
    always_comb begin
        c_we   = 1'b0;
        c_addr = A_W'(scan_addr);
        c_wd   = col_reg;
        if (ctl.shift_step) begin
            c_we   = 1'b1;
            c_addr = A_W'(i_reg);
            c_wd   = col_q_reg;
        end else if (ctl.put) begin
            c_we   = 1'b1;
            c_addr = A_W'(ins_at);
        end else if (ctl.shift_start) begin
            c_addr = A_W'(total_reg - C_W'(1));
        end else if (ctl.scan_start && req_reg) begin
            c_addr = A_W'(rd_addr);
        end else if (ctl.scan_next) begin
            // first scan cycle reads store[base], later ones the next word
            c_addr = scan_vld_reg ? A_W'(scan_addr + (C_W+1)'(1)) : A_W'(scan_addr);
        end
    end

    // shift reads store[i-2] while writing store[i] with data of store[i-1]
    logic [A_W-1:0] c_raddr;
    assign c_raddr = ctl.shift_step ? A_W'(i_reg - C_W'(2)) : c_addr;

    always_ff @(posedge aclk) begin
        if (c_we) col_mem[c_addr] <= c_wd;
        col_q_reg <= col_mem[c_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pidx_reg     <= '0;
            total_reg    <= '0;
            span_reg     <= '0;
            scan_vld_reg <= 1'b0;
            inc_ph_reg   <= 1'b0;
            mv_reg       <= 1'b0;
            val_cap_reg  <= 1'b0;
        end else begin
            if (ctl.clr_step) pidx_reg <= pidx_reg + P_W'(1);
            if (ctl.load_req) begin
                req_reg <= s_req_type;
                row_reg <= s_row;
                col_reg <= s_col;
                pos_reg <= s_position;
                val_reg <= '0;
                val_cap_reg <= 1'b0;
            end
            if (ctl.cap_lo) base_reg <= ptr_q_reg;
            // insert grows the row by one; base pointer is unchanged
            if (ctl.cap_hi) end_reg <= ptr_q_reg;
            else if (ctl.commit) end_reg <= end_reg + C_W'(1);
            if (ctl.scan_start) val_cap_reg <= 1'b1;
            else if (val_cap_reg) begin
                val_reg     <= col_q_reg;
                val_cap_reg <= 1'b0;
            end
            // scan: first cycle issues read, later cycles compare
            if (ctl.cap_hi) begin
                k_reg        <= '0;
                scan_vld_reg <= 1'b0;
            end else if (ctl.scan_next) begin
                if (scan_vld_reg) k_reg <= k_reg + C_W'(1);
                scan_vld_reg <= 1'b1;
            end else if (ctl.shift_start && scan_vld_reg && !sts.hit_gt) begin
                // last compared word was smaller: insert behind it
                k_reg <= k_reg + C_W'(1);
            end
            if (ctl.shift_start) i_reg <= total_reg;
            else if (ctl.shift_step) i_reg <= i_reg - C_W'(1);
            if (ctl.inc_start) begin
                pidx_reg   <= P_W'(row_reg) + P_W'(1);
                inc_ph_reg <= 1'b0;
            end else if (ctl.inc_step) begin
                inc_ph_reg <= ~inc_ph_reg;
                if (inc_ph_reg) pidx_reg <= pidx_reg + P_W'(1);
            end
            if (ctl.commit) begin
                total_reg <= total_reg + C_W'(1);
                if ({1'b0, col_reg} + (K_W+1)'(1) > span_reg)
                    span_reg <= {1'b0, col_reg} + (K_W+1)'(1);
            end
            if (ctl.set_status) stat_reg <= ctl.status;
            if (ctl.out_load) mv_reg <= 1'b1;
            else if (m_ready) mv_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            o_stat_reg <= stat_reg;
            // read data is still in col_q_reg on the first result cycle
            o_val_reg  <= (stat_reg == sbrs_pkg::ST_OK && req_reg)
                          ? (val_cap_reg ? col_q_reg : val_reg) : '0;
            o_rc_reg   <= (stat_reg == sbrs_pkg::ST_ROW_OOR) ? '0 : 11'(cnt);
            o_tc_reg   <= 11'(total_reg);
            o_span_reg <= 17'(span_reg);
        end
    end

    logic scan_last;
    assign scan_last = (k_reg >= cnt) || (scan_addr >= (C_W+1)'(sbrs_pkg::MAX_ENTRIES));

    always_comb begin
        sts            = '0;
        sts.clr_last   = (pidx_reg == P_W'(sbrs_pkg::MAX_ROWS));
        sts.row_oor    = ({1'b0, row_reg} >= rows_lim);
        sts.pos_ok     = (11'(pos_reg) < 11'(cnt));
        sts.is_read    = req_reg;
        sts.full       = (total_reg >= C_W'(sbrs_pkg::MAX_ENTRIES));
        sts.scan_end   = scan_vld_reg ? 1'b0 : scan_last;
        sts.hit_eq     = 1'b0;
        sts.hit_gt     = 1'b0;
        if (scan_vld_reg) begin
            // compare word at k; step or end
            if (col_q_reg == col_reg)      sts.hit_eq = 1'b1;
            else if (col_q_reg > col_reg)  sts.hit_gt = 1'b1;
            else if ((k_reg + C_W'(1) >= cnt) ||
                     (scan_addr + (C_W+1)'(1) >= (C_W+1)'(sbrs_pkg::MAX_ENTRIES)))
                sts.scan_end = 1'b1;
        end
        sts.shift_done = (i_reg == ins_at);
        sts.inc_last   = (pidx_reg == P_W'(sbrs_pkg::MAX_ROWS));
        sts.inc_pend   = ~inc_ph_reg;
    end

    assign out_busy      = mv_reg && !m_ready;
    assign m_valid       = mv_reg;
    assign m_status      = o_stat_reg;
    assign m_col_value   = o_val_reg;
    assign m_row_count   = o_rc_reg;
    assign m_total_count = o_tc_reg;
    assign m_col_span    = o_span_reg;

endmodule

// ===== design/sparse_binary_row_store_unit.sv =====
// ----------------------------------------------------------------------------
// sparse_binary_row_store_unit: sorted compressed-row binary matrix store
// Inserts (row, col) entries in sorted order and reads entries by position.
// ----------------------------------------------------------------------------
//  channel | direction | words
//  s_*     | in        | req_type, row, col, position
//  m_*     | out       | status, col_value, row_count, total_count, col_span
//  cfg     | in        | num_rows, written when cfg_we is high
//
// One request at a time. A read passes the pointer reads, the position check
// and the store read before its result; a row out of range ends after the
// pointer reads. An insert reads the pointers, scans the row, shifts the later
// words up, writes the column and then reads and writes back each later row
// pointer; a duplicate ends after the scan.
// After reset a clearing pass zeroes the MAX_ROWS+1 row pointers.
// A waiting result holds the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
module sparse_binary_row_store_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [8:0]  cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_req_type,
    input  logic [7:0]  s_row,
    input  logic [15:0] s_col,
    input  logic [9:0]  s_position,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_col_value,
    output logic [10:0] m_row_count,
    output logic [10:0] m_total_count,
    output logic [16:0] m_col_span
);

    logic [8:0] num_rows_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn)    num_rows_reg <= 9'd256;
        else if (cfg_we) num_rows_reg <= cfg_wdata;
    end

    sbrs_pkg::ctl_t ctl;
    sbrs_pkg::sts_t sts;
    logic           out_busy;

    sbrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_busy (out_busy),
        .sts      (sts),
        .ctl      (ctl)
    );

    sbrs_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .num_rows      (num_rows_reg),
        .s_req_type    (s_req_type),
        .s_row         (s_row),
        .s_col         (s_col),
        .s_position    (s_position),
        .ctl           (ctl),
        .sts           (sts),
        .out_busy      (out_busy),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_status      (m_status),
        .m_col_value   (m_col_value),
        .m_row_count   (m_row_count),
        .m_total_count (m_total_count),
        .m_col_span    (m_col_span)
    );

endmodule
